// ----- sv/atrc_pkg.sv -----
// Package for the AT response line classifier: line limit, counter width,
// class codes and the prefix tables used by the matcher.
// No dependencies.
package atrc_pkg;

    // Longest line kept before a forced cut
    localparam int LINE_LIMIT = 499;
    localparam int CNT_W      = $clog2(LINE_LIMIT + 1);
    localparam int LEN_W      = 9;

    localparam int NUM_PREFIX = 6;
    localparam int PFX_IDX_W  = 3;
    localparam int PFX_POS_W  = 4;

    // Line class codes
    localparam logic [2:0] CLASS_OTHER   = 3'd0;
    localparam logic [2:0] CLASS_DATA    = 3'd1;
    localparam logic [2:0] CLASS_SEND_OK = 3'd2;
    localparam logic [2:0] CLASS_ACK     = 3'd3;
    localparam logic [2:0] CLASS_PROMPT  = 3'd4;

    // Prefix slots, in priority order
    localparam logic [2:0] PFX_IPD       = 3'd0;
    localparam logic [2:0] PFX_SEND_OK   = 3'd1;
    localparam logic [2:0] PFX_OK        = 3'd2;
    localparam logic [2:0] PFX_READY     = 3'd3;
    localparam logic [2:0] PFX_NO_CHANGE = 3'd4;
    localparam logic [2:0] PFX_PROMPT    = 3'd5;

    // Line terminators
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef logic [NUM_PREFIX-1:0] alive_t;
    typedef logic [CNT_W-1:0]      count_t;

    // Number of characters in each prefix
    function automatic logic [PFX_POS_W-1:0] pfx_len(input logic [PFX_IDX_W-1:0] k);
        logic [PFX_POS_W-1:0] len;
        case (k)
            PFX_IPD:       len = 4'd4;
            PFX_SEND_OK:   len = 4'd7;
            PFX_OK:        len = 4'd2;
            PFX_READY:     len = 4'd5;
            PFX_NO_CHANGE: len = 4'd9;
            PFX_PROMPT:    len = 4'd1;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    // Class reported when a prefix wins
    function automatic logic [2:0] pfx_class(input logic [PFX_IDX_W-1:0] k);
        logic [2:0] cls;
        case (k)
            PFX_IPD:       cls = CLASS_DATA;
            PFX_SEND_OK:   cls = CLASS_SEND_OK;
            PFX_OK:        cls = CLASS_ACK;
            PFX_READY:     cls = CLASS_ACK;
            PFX_NO_CHANGE: cls = CLASS_ACK;
            PFX_PROMPT:    cls = CLASS_PROMPT;
            default:       cls = CLASS_OTHER;
        endcase
        return cls;
    endfunction

    // Expected character of prefix k at position pos (only read below pfx_len)
    function automatic logic [7:0] pfx_char(input logic [PFX_IDX_W-1:0] k,
                                            input logic [PFX_POS_W-1:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            PFX_IPD:
                case (pos)
                    4'd0:    ch = "+";
                    4'd1:    ch = "I";
                    4'd2:    ch = "P";
                    4'd3:    ch = "D";
                    default: ch = 8'h00;
                endcase
            PFX_SEND_OK:
                case (pos)
                    4'd0:    ch = "S";
                    4'd1:    ch = "E";
                    4'd2:    ch = "N";
                    4'd3:    ch = "D";
                    4'd4:    ch = " ";
                    4'd5:    ch = "O";
                    4'd6:    ch = "K";
                    default: ch = 8'h00;
                endcase
            PFX_OK:
                case (pos)
                    4'd0:    ch = "O";
                    4'd1:    ch = "K";
                    default: ch = 8'h00;
                endcase
            PFX_READY:
                case (pos)
                    4'd0:    ch = "r";
                    4'd1:    ch = "e";
                    4'd2:    ch = "a";
                    4'd3:    ch = "d";
                    4'd4:    ch = "y";
                    default: ch = 8'h00;
                endcase
            PFX_NO_CHANGE:
                case (pos)
                    4'd0:    ch = "n";
                    4'd1:    ch = "o";
                    4'd2:    ch = " ";
                    4'd3:    ch = "c";
                    4'd4:    ch = "h";
                    4'd5:    ch = "a";
                    4'd6:    ch = "n";
                    4'd7:    ch = "g";
                    4'd8:    ch = "e";
                    default: ch = 8'h00;
                endcase
            PFX_PROMPT:
                case (pos)
                    4'd0:    ch = ">";
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- sv/atrc_prefix_match.sv -----
// Prefix matcher: clears alive bits on a mismatching character and picks
// the class of the line from the alive bits and the character count.
// Depends on atrc_pkg.
module atrc_prefix_match (
    input  atrc_pkg::alive_t    alive,      // alive bits before this byte
    input  atrc_pkg::count_t    count,      // characters already in the line
    input  logic [7:0]          rx_byte,
    output atrc_pkg::alive_t    alive_next, // alive bits after taking rx_byte
    output logic [2:0]          line_class  // class of the line as it stands
);
    import atrc_pkg::*;

    // Drop every prefix whose character at this position differs
    always_comb
    begin
        alive_next = alive;
        for (int k = 0; k < NUM_PREFIX; k++)
        begin
            if ((count < CNT_W'(pfx_len(PFX_IDX_W'(k)))) &&
                (rx_byte != pfx_char(PFX_IDX_W'(k), count[PFX_POS_W-1:0])))
            begin
                alive_next[k] = 1'b0;
            end
        end
    end

    // Pick the first complete prefix in priority order
    always_comb
    begin
        line_class = CLASS_OTHER;
        for (int k = NUM_PREFIX - 1; k >= 0; k--)
        begin
            if (alive[k] && (count >= CNT_W'(pfx_len(PFX_IDX_W'(k)))))
            begin
                line_class = pfx_class(PFX_IDX_W'(k));
            end
        end
    end

endmodule

// ----- sv/at_response_line_classifier.sv -----
// Top level of the AT response line classifier: line state, stream ports
// and the result register.
// Depends on atrc_pkg and atrc_prefix_match.
//
//  Channel  | Dir | tdata (low bit up)                       | tuser
//  ---------+-----+------------------------------------------+-----------
//  s_axis   | in  | rx_byte[7:0]                             | -
//  m_axis   | out | line_class[2:0], line_length[11:3], 0    | line_cut
//
// One word is taken per cycle; a finished line shows up on m_axis the
// cycle after its terminating word. The line counter and the alive bits
// update at the input handshake; the result register sits in front of
// m_axis. s_axis stalls only while a result is held and m_axis_tready is
// low. Reset clears the counter, sets all alive bits and empties the
// result register.
module at_response_line_classifier (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [2:0] line_class, [11:3] line_length
    output logic        m_axis_tuser    // [0] line_cut
);
    import atrc_pkg::*;

    count_t     count_reg;
    count_t     count_next;
    alive_t     alive_reg;
    alive_t     alive_next;
    alive_t     alive_match;
    logic [2:0] class_now;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [2:0] out_class_reg;
    logic [LEN_W-1:0] out_length_reg;
    logic       out_cut_reg;

    logic       in_accept;
    logic       is_term;
    logic       take_char;
    logic       emit_line;

    // Match the byte against the prefixes
    atrc_prefix_match u_match (
        .alive      (alive_reg),
        .count      (count_reg),
        .rx_byte    (s_axis_tdata),
        .alive_next (alive_match),
        .line_class (class_now)
    );

    // Classify the incoming word
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_term       = (s_axis_tdata == CHAR_LF) || (s_axis_tdata == CHAR_CR);
    assign take_char     = !is_term && (count_reg < CNT_W'(LINE_LIMIT));
    assign emit_line     = !take_char && (count_reg != '0);

    // Advance the line state
    always_comb
    begin
        count_next = count_reg;
        alive_next = alive_reg;
        if (in_accept)
        begin
            if (take_char)
            begin
                count_next = count_reg + 1'b1;
                alive_next = alive_match;
            end
            else
            begin
                count_next = '0;
                alive_next = '1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            alive_reg <= '1;
        end
        else
        begin
            count_reg <= count_next;
            alive_reg <= alive_next;
        end
    end

    // Hold a result until m_axis takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept && emit_line)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (in_accept && emit_line)
        begin
            out_class_reg  <= class_now;
            out_length_reg <= LEN_W'(count_reg);
            out_cut_reg    <= !is_term;
        end
    end

    // Drive the result port
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_length_reg, out_class_reg};
    assign m_axis_tuser  = out_cut_reg;

endmodule

// ----- tb/sv/atrc_line_checker.sv -----
// Checker for the AT response line classifier: watches both stream channels,
// predicts each finished line from the received words and compares results.
// Depends on atrc_pkg.
module atrc_line_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [2:0] line_class, [11:3] line_length
    input  logic        m_axis_tuser,   // [0] line_cut

    output int          fail_count,
    output int          pending_lines
);

    timeunit 1ns;
    timeprecision 1ps;

    import atrc_pkg::*;

    typedef struct packed {
        logic [2:0]       line_class;
        logic [LEN_W-1:0] line_length;
        logic             line_cut;
    } line_result_t;

    // Prefix texts in priority order and the class each one reports
    string      prefix_text  [NUM_PREFIX] = '{"+IPD", "SEND OK", "OK", "ready",
                                              "no change", ">"};
    logic [2:0] prefix_class [NUM_PREFIX] = '{CLASS_DATA, CLASS_SEND_OK, CLASS_ACK,
                                              CLASS_ACK, CLASS_ACK, CLASS_PROMPT};

    int           line_chars;
    alive_t       still_matching;
    line_result_t expected_lines[$];

    // Advance the line state by one received word; queue a result on line end
    task automatic absorb_byte(input logic [7:0] ch);
        logic         is_term;
        logic         found;
        line_result_t rec;
        is_term = (ch == CHAR_LF) || (ch == CHAR_CR);
        if (!is_term && line_chars < LINE_LIMIT)
        begin
            for (int k = 0; k < NUM_PREFIX; k++)
                if (line_chars < prefix_text[k].len() &&
                    ch != prefix_text[k][line_chars])
                    still_matching[k] = 1'b0;
            line_chars++;
        end
        else if (line_chars != 0)
        begin
            found = 1'b0;
            rec.line_class = CLASS_OTHER;
            for (int k = 0; k < NUM_PREFIX; k++)
                if (!found && still_matching[k] && line_chars >= prefix_text[k].len())
                begin
                    rec.line_class = prefix_class[k];
                    found = 1'b1;
                end
            rec.line_length = line_chars[LEN_W-1:0];
            rec.line_cut    = !is_term;
            expected_lines.push_back(rec);
            line_chars     = 0;
            still_matching = '1;
        end
    endtask

    // Compare one delivered result with the oldest expected line
    task automatic check_result();
        line_result_t want;
        logic [2:0]       got_class;
        logic [LEN_W-1:0] got_length;
        got_class  = m_axis_tdata[2:0];
        got_length = m_axis_tdata[3 +: LEN_W];
        if (expected_lines.size() == 0)
        begin
            $error("unexpected line result: class %0d, length %0d, cut %0d",
                   got_class, got_length, m_axis_tuser);
            fail_count++;
        end
        else
        begin
            want = expected_lines.pop_front();
            if (got_class !== want.line_class)
            begin
                $error("line_class: expected %0d, got %0d", want.line_class, got_class);
                fail_count++;
            end
            if (got_length !== want.line_length)
            begin
                $error("line_length: expected %0d, got %0d", want.line_length, got_length);
                fail_count++;
            end
            if (m_axis_tuser !== want.line_cut)
            begin
                $error("line_cut: expected %0d, got %0d", want.line_cut, m_axis_tuser);
                fail_count++;
            end
        end
    endtask

    // Sample both channels at the rising edge; outputs first, then inputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_chars     = 0;
            still_matching = '1;
            expected_lines.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                absorb_byte(s_axis_tdata);
        end
        pending_lines = expected_lines.size();
    end

endmodule

// ----- tb/sv/tb.sv -----
// Testbench top for the AT response line classifier: clock, reset, word
// stimulus with idle and stall phases, and the final verdict.
// Depends on atrc_pkg, at_response_line_classifier and atrc_line_checker.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atrc_pkg::*;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count;
    int pending_lines;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int sent_bytes     = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;

    string prefix_text [NUM_PREFIX] = '{"+IPD", "SEND OK", "OK", "ready",
                                        "no change", ">"};

    at_response_line_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    atrc_line_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending_lines (pending_lines)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stop a hung run
    initial
    begin
        #5_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Drive the receiver ready; a hold request forces a long stall
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = 150;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left--;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Any byte except a line terminator
    function automatic logic [7:0] pick_text_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    // Offer one word, with random idle cycles first; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        sent_bytes++;
    endtask

    task automatic send_line(input string text, input logic [7:0] term);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i]);
        send_byte(term);
    endtask

    // Fill a line up to the limit, starting with lead, then send closer
    task automatic send_limit_line(input string lead, input logic [7:0] closer);
        for (int i = 0; i < LINE_LIMIT; i++)
            send_byte(i < lead.len() ? lead[i] : pick_text_byte());
        send_byte(closer);
    endtask

    // Mostly prefix lines, some cut short or corrupted, some noise and empty lines
    task automatic send_random_line();
        int         k;
        int         keep;
        int         mut_at;
        logic [7:0] b;
        k = $urandom_range(NUM_PREFIX + 1);
        if (k < NUM_PREFIX)
        begin
            keep = prefix_text[k].len();
            if ($urandom_range(3) == 0)
                keep = $urandom_range(keep);
            mut_at = -1;
            if ($urandom_range(4) == 0)
                mut_at = $urandom_range(keep);
            for (int n = 0; n < keep; n++)
            begin
                b = prefix_text[k][n];
                if (n == mut_at)
                    b = pick_text_byte();
                send_byte(b);
            end
            for (int n = $urandom_range(6); n > 0; n--)
                send_byte(pick_text_byte());
        end
        else if (k == NUM_PREFIX)
        begin
            for (int n = $urandom_range(1, 12); n > 0; n--)
                send_byte(8'($urandom_range(255)));
        end
        case ($urandom_range(3))
            0: send_byte(CHAR_CR);
            1: send_byte(CHAR_LF);
            2:
            begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            default:
            begin
                send_byte(CHAR_LF);
                send_byte(CHAR_CR);
            end
        endcase
    endtask

    task automatic send_random_run(input int idle_pct, input int stall_pct, input int words);
        int run_end;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        run_end        = sent_bytes + words;
        while (sent_bytes < run_end)
            send_random_line();
    endtask

    initial
    begin
        int w;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed lines: empty line, each prefix, short prefixes, zero byte
        send_byte(CHAR_CR);
        send_line("+IPD,0,4:abcd", CHAR_CR);
        send_byte(CHAR_LF);
        send_line("SEND OK", CHAR_LF);
        send_line("OK", CHAR_CR);
        send_line("OKAY", CHAR_LF);
        send_line("ready", CHAR_LF);
        send_line("no change", CHAR_CR);
        send_line(">", CHAR_CR);
        send_line("+IP", CHAR_CR);
        send_line("SEND O", CHAR_LF);
        send_line("no chang", CHAR_LF);
        send_line("O", CHAR_CR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_line("OK", CHAR_CR);

        // Limit: terminator at the limit, then a dropped byte at the limit
        send_limit_line("ready", CHAR_CR);
        send_limit_line("+IPD", "Z");
        send_line("OK", CHAR_LF);

        // Random lines with neither idle nor stall phases
        send_random_run(0, 0, 115);

        // Hold the receiver off while short lines keep coming
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++)
            send_line("OK", CHAR_CR);

        send_random_run(70, 0, 115);
        send_random_run(0, 70, 115);
        send_random_run(27, 27, 115);

        s_axis_tvalid <= 1'b0;
        for (w = 0; w < 20000 && pending_lines != 0; w++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending_lines == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
